FILE: sv/bbps_pkg.sv
// bbps_pkg: types and constants shared by the buzzer beep pattern sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package bbps_pkg;

   localparam int ModeBits   = 3;
   localparam int VolumeBits = 8;
   localparam int BeepBits   = 16;
   localparam int NowBits    = 32;
   localparam int CsrIdxBits = 2;
   localparam int CsrDatBits = 16;

   typedef enum logic [ModeBits-1:0] {
      MODE_OFF    = 3'd0,
      MODE_ONCE   = 3'd1,
      MODE_DOUBLE = 3'd2,
      MODE_TRIPLE = 3'd3,
      MODE_CONT   = 3'd4,
      MODE_ALARM  = 3'd5
   } mode_type;

   // register indexes on the csr port
   localparam logic [CsrIdxBits-1:0] CSR_SOUND_ENABLE = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_DRIVE_VOLUME = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_BEEP_MS      = 2'd2;

   // item op codes
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MODE = 1'b1;

   localparam logic [VolumeBits-1:0] VOLUME_RESET = 8'd128;
   localparam logic [BeepBits-1:0]   BEEP_RESET   = 16'd200;

   // beats in a triple pattern; a double pattern stops one earlier
   localparam logic [2:0] TRIPLE_BEATS = 3'd3;
   localparam logic [2:0] DOUBLE_BEATS = 3'd2;

   typedef struct packed {
      logic                  op;
      logic [ModeBits-1:0]   new_mode;
      logic [NowBits-1:0]    now_ms;
   } item_type;

   typedef struct packed {
      logic                  sound_enable;
      logic [VolumeBits-1:0] drive_volume;
      logic [BeepBits-1:0]   beep_ms;
   } cfg_type;

endpackage

`default_nettype wire

FILE: sv/bbps_csr.sv
// bbps_csr: configuration registers of the beep sequencer
// depends on bbps_pkg
`default_nettype none

module bbps_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [bbps_pkg::CsrIdxBits-1:0] csr_index,
   input  wire logic [bbps_pkg::CsrDatBits-1:0] csr_wdata,
   output bbps_pkg::cfg_type                    cfg
);
   import bbps_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sound_enable <= 1'b1;
         cfg_ff.drive_volume <= VOLUME_RESET;
         cfg_ff.beep_ms      <= BEEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SOUND_ENABLE: cfg_ff.sound_enable <= csr_wdata[0];
            CSR_DRIVE_VOLUME: cfg_ff.drive_volume <= csr_wdata[VolumeBits-1:0];
            CSR_BEEP_MS:      cfg_ff.beep_ms      <= csr_wdata[BeepBits-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: sv/bbps_in_stage.sv
// bbps_in_stage: input register holding one request beat
// depends on bbps_pkg
`default_nettype none

module bbps_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  bbps_pkg::item_type      in_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bbps_pkg::item_type      out_item
);
   import bbps_pkg::*;

   logic     valid_ff;
   item_type item_ff;

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

FILE: sv/bbps_core.sv
// bbps_core: pattern state, next-state logic and result register
// depends on bbps_pkg; fed by bbps_in_stage and bbps_csr
`default_nettype none

module bbps_core #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  bbps_pkg::cfg_type                    cfg,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  bbps_pkg::item_type                   in_item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bbps_pkg::VolumeBits-1:0]      rsp_drive_level,
   output logic [bbps_pkg::ModeBits-1:0]        rsp_active_mode,
   output logic                                 rsp_sounding
);
   import bbps_pkg::*;

   mode_type              mode_ff,  mode_in;
   logic                  on_ff,    on_in;
   logic [2:0]            count_ff, count_in;
   logic                  phase_ff, phase_in;
   logic [TIME_BITS-1:0]  mark_ff,  mark_in;
   logic [VolumeBits-1:0] drive_ff, drive_in;

   logic                  rsp_valid_ff;
   logic [VolumeBits-1:0] rsp_level_ff;
   logic [ModeBits-1:0]   rsp_mode_ff;
   logic                  rsp_sound_ff;

   logic fire;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   always_comb begin
      logic [TIME_BITS-1:0] t;
      logic [TIME_BITS-1:0] elapsed;
      logic                 due;
      logic [2:0]           next_count;
      logic [2:0]           limit;
      logic                 silent;
      mode_type             req_mode;

      mode_in  = mode_ff;
      on_in    = on_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      mark_in  = mark_ff;
      drive_in = drive_ff;
      silent   = 1'b0;

      t          = TIME_BITS'(in_item.now_ms);
      elapsed    = t - mark_ff;
      due        = elapsed >= TIME_BITS'(cfg.beep_ms);
      next_count = count_ff + 3'd1;
      limit      = (mode_ff == MODE_DOUBLE) ? DOUBLE_BEATS : TRIPLE_BEATS;
      req_mode   = mode_type'(in_item.new_mode);

      if (in_item.op == OP_TICK) begin
         if (!cfg.sound_enable) begin
            silent = 1'b1;
         end else begin
            case (mode_ff)
               MODE_ONCE: begin
                  if (!on_ff) begin
                     on_in    = 1'b1;
                     mark_in  = t;
                     drive_in = cfg.drive_volume;
                  end else if (due) begin
                     silent = 1'b1;
                  end else begin
                     drive_in = cfg.drive_volume;
                  end
               end
               MODE_DOUBLE, MODE_TRIPLE: begin
                  if (count_ff == 3'd0) begin
                     drive_in = cfg.drive_volume;
                     on_in    = 1'b1;
                     count_in = 3'd1;
                     mark_in  = t;
                  end else if (on_ff && due) begin
                     // a double pattern ends after its second beep
                     if (mode_ff == MODE_DOUBLE && count_ff >= DOUBLE_BEATS) begin
                        silent = 1'b1;
                     end else begin
                        drive_in = '0;
                        on_in    = 1'b0;
                        mark_in  = t;
                     end
                  end else if (!on_ff && due) begin
                     if (next_count > limit || next_count == 3'd0) begin
                        silent = 1'b1;
                     end else begin
                        count_in = next_count;
                        drive_in = cfg.drive_volume;
                        on_in    = 1'b1;
                        mark_in  = t;
                     end
                  end
               end
               MODE_CONT: begin
                  drive_in = cfg.drive_volume;
               end
               MODE_ALARM: begin
                  if (due) begin
                     phase_in = !phase_ff;
                     drive_in = !phase_ff ? cfg.drive_volume : '0;
                     mark_in  = t;
                  end
               end
               default: begin
                  drive_in = '0;
               end
            endcase
         end
      end else begin
         // unknown codes, sounding modes while disabled and off during a
         // protected beep all leave the state alone
         if (in_item.new_mode <= MODE_ALARM
             && (cfg.sound_enable || req_mode == MODE_OFF)
             && !(req_mode == MODE_OFF && on_ff
                  && (mode_ff == MODE_ONCE || mode_ff == MODE_DOUBLE))) begin
            mark_in  = '0;
            count_in = 3'd0;
            on_in    = 1'b0;
            phase_in = 1'b0;
            mode_in  = req_mode;
            drive_in = (req_mode == MODE_CONT) ? cfg.drive_volume : '0;
         end
      end

      if (silent) begin
         mode_in  = MODE_OFF;
         on_in    = 1'b0;
         count_in = 3'd0;
         phase_in = 1'b0;
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ONCE;
         on_ff    <= 1'b0;
         count_ff <= 3'd0;
         phase_ff <= 1'b0;
         mark_ff  <= '0;
         drive_ff <= '0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         on_ff    <= on_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
         mark_ff  <= mark_in;
         drive_ff <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_level_ff <= drive_in;
         rsp_mode_ff  <= mode_in;
         rsp_sound_ff <= drive_in != '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_level = rsp_level_ff;
   assign rsp_active_mode = rsp_mode_ff;
   assign rsp_sounding    = rsp_sound_ff;

endmodule

`default_nettype wire

FILE: sv/buzzer_beep_pattern_sequencer.sv
// Buzzer beep pattern sequencer: takes one tick or mode command per cycle
// and returns one beat per item with the drive level, the mode in force
// and a sounding flag. An item goes through an input register and then a
// single next-state step into the result register, which holds its result
// until it is taken; items flow at one per cycle while the response side
// keeps taking beats. Beep, gap and alarm half period times follow
// beep_ms, measured as wrapping differences of now_ms over TIME_BITS bits.
// The user must write configuration through the csr port only while no
// item is in flight; the block itself does not enforce this.
`default_nettype none

module buzzer_beep_pattern_sequencer #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_op,
   input  wire logic [bbps_pkg::ModeBits-1:0]   req_new_mode,
   input  wire logic [bbps_pkg::NowBits-1:0]    req_now_ms,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bbps_pkg::VolumeBits-1:0]      rsp_drive_level,
   output logic [bbps_pkg::ModeBits-1:0]        rsp_active_mode,
   output logic                                 rsp_sounding,
   input  wire logic                            csr_wr_en,
   input  wire logic [bbps_pkg::CsrIdxBits-1:0] csr_index,
   input  wire logic [bbps_pkg::CsrDatBits-1:0] csr_wdata
);
   import bbps_pkg::*;

   cfg_type  cfg;
   item_type req_item;
   item_type stage_item;
   logic     stage_valid;
   logic     stage_ready;

   assign req_item.op       = req_op;
   assign req_item.new_mode = req_new_mode;
   assign req_item.now_ms   = req_now_ms;

   bbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bbps_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   bbps_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .in_valid        (stage_valid),
      .in_ready        (stage_ready),
      .in_item         (stage_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_level (rsp_drive_level),
      .rsp_active_mode (rsp_active_mode),
      .rsp_sounding    (rsp_sounding)
   );

endmodule

`default_nettype wire

FILE: sv/bbps_checker.sv
// bbps_checker: port-level checks of the beep sequencer
// depends on bbps_pkg; bound to buzzer_beep_pattern_sequencer below
`default_nettype none

module bbps_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [bbps_pkg::VolumeBits-1:0] rsp_drive_level,
   input wire logic [bbps_pkg::ModeBits-1:0]   rsp_active_mode,
   input wire logic                            rsp_sounding
);
   import bbps_pkg::*;

   // a stalled beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_sound_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sounding == (rsp_drive_level != '0)))
      else $error("sounding flag disagrees with drive level");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_active_mode <= MODE_ALARM)
      else $error("reported mode outside the defined codes");

   // off mode never drives the buzzer
   a_off_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_active_mode == MODE_OFF |-> !rsp_sounding)
      else $error("buzzer driven while off");

   // no beat can come out of an empty pipe straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat straight after reset");

endmodule

bind buzzer_beep_pattern_sequencer bbps_checker u_bbps_checker (.*);

`default_nettype wire

FILE: tb/tb_buzzer_beep_pattern_sequencer.sv
// Self-checking testbench for the buzzer beep pattern sequencer: a short table of
// directed items, then phases of random tick/command runs under several register
// settings, checked beat by beat against a built-in predictor. Needs only bbps_pkg and the RTL.
`timescale 1ns / 1ps

module tb_buzzer_beep_pattern_sequencer;
   import bbps_pkg::*;

   localparam int PlanRows   = 29;
   localparam int PhaseCount = 8;
   localparam int PhaseItems = 250;
   localparam int ShowLimit  = 100;
   localparam logic [CsrIdxBits-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [VolumeBits-1:0] level;
      mode_type              mode;
      logic                  sounding;
   } drive_beat_type;

   typedef struct packed {
      logic                  op;
      logic [ModeBits-1:0]   sel;
      logic [NowBits-1:0]    stamp;
      logic                  typed;
      logic [VolumeBits-1:0] level;
      mode_type              mode;
   } plan_row_type;

   // rows marked typed carry their expected beat; the rest go through the predictor
   localparam plan_row_type PLAN [PlanRows] = '{
      '{OP_MODE, 3'd6,        32'd0,           1'b1, 8'd0,   MODE_ONCE},   // unknown mode
      '{OP_TICK, MODE_OFF,    32'd0,           1'b1, 8'd128, MODE_ONCE},
      '{OP_MODE, MODE_OFF,    32'd0,           1'b1, 8'd128, MODE_ONCE},   // beep protected
      '{OP_TICK, MODE_OFF,    32'd199,         1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd200,         1'b1, 8'd0,   MODE_OFF},
      '{OP_MODE, MODE_DOUBLE, 32'd0,           1'b1, 8'd0,   MODE_DOUBLE},
      '{OP_TICK, MODE_OFF,    32'hFFFF_FF00,   1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'h0000_00C8,   1'b0, 8'd0,   MODE_OFF},    // wraps past zero
      '{OP_TICK, MODE_OFF,    32'd400,         1'b0, 8'd0,   MODE_OFF},
      '{OP_MODE, MODE_OFF,    32'd0,           1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd600,         1'b0, 8'd0,   MODE_OFF},    // double ends
      '{OP_MODE, MODE_TRIPLE, 32'd0,           1'b1, 8'd0,   MODE_TRIPLE},
      '{OP_TICK, MODE_OFF,    32'd1000,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd1200,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd1400,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd1600,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd1800,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd2000,        1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd2200,        1'b0, 8'd0,   MODE_OFF},
      '{OP_MODE, MODE_TRIPLE, 32'd0,           1'b1, 8'd0,   MODE_TRIPLE},
      '{OP_TICK, MODE_OFF,    32'd3000,        1'b0, 8'd0,   MODE_OFF},
      '{OP_MODE, MODE_OFF,    32'd0,           1'b1, 8'd0,   MODE_OFF},    // triple not protected
      '{OP_MODE, MODE_CONT,   32'd0,           1'b1, 8'd128, MODE_CONT},
      '{OP_MODE, MODE_ALARM,  32'd0,           1'b1, 8'd0,   MODE_ALARM},
      '{OP_TICK, MODE_OFF,    32'd0,           1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'd200,         1'b0, 8'd0,   MODE_OFF},
      '{OP_TICK, MODE_OFF,    32'hFFFF_FFFF,   1'b0, 8'd0,   MODE_OFF},
      '{OP_MODE, 3'd7,        32'hFFFF_FFFF,   1'b0, 8'd0,   MODE_OFF},
      '{OP_MODE, MODE_OFF,    32'd0,           1'b1, 8'd0,   MODE_OFF}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = OP_TICK;
   logic [ModeBits-1:0]   req_new_mode = '0;
   logic [NowBits-1:0]    req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [VolumeBits-1:0] rsp_drive_level;
   logic [ModeBits-1:0]   rsp_active_mode;
   logic                  rsp_sounding;
   logic                  csr_wr_en = 1'b0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [CsrDatBits-1:0] csr_wdata = '0;

   // predictor copy of the registers and the sequencer state
   logic                  snd_en     = 1'b1;
   logic [VolumeBits-1:0] vol_set    = VOLUME_RESET;
   logic [BeepBits-1:0]   beep_len   = BEEP_RESET;
   mode_type              cur_mode   = MODE_ONCE;
   logic                  tone_on    = 1'b0;
   logic [2:0]            beeps_done = 3'd0;
   logic                  alarm_high = 1'b0;
   logic [NowBits-1:0]    mark_ms    = '0;
   logic [VolumeBits-1:0] held_level = '0;

   drive_beat_type level_mode_q[$];
   int             mismatches = 0;
   bit             calm = 1'b0;

   always #5 clock = ~clock;

   buzzer_beep_pattern_sequencer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_new_mode    (req_new_mode),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_level (rsp_drive_level),
      .rsp_active_mode (rsp_active_mode),
      .rsp_sounding    (rsp_sounding),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   function automatic void go_quiet();
      cur_mode   = MODE_OFF;
      tone_on    = 1'b0;
      beeps_done = 3'd0;
      alarm_high = 1'b0;
      held_level = '0;
   endfunction

   function automatic void apply_tick(input logic [NowBits-1:0] now);
      logic due;
      due = (now - mark_ms) >= {16'd0, beep_len};
      if (!snd_en) begin
         go_quiet();
         return;
      end
      case (cur_mode)
         MODE_ONCE: begin
            if (!tone_on) begin
               tone_on    = 1'b1;
               mark_ms    = now;
               held_level = vol_set;
            end else if (due) begin
               go_quiet();
            end else begin
               held_level = vol_set;
            end
         end
         MODE_DOUBLE, MODE_TRIPLE: begin
            if (beeps_done == 3'd0) begin
               held_level = vol_set;
               tone_on    = 1'b1;
               beeps_done = 3'd1;
               mark_ms    = now;
            end else if (tone_on && due) begin
               if (cur_mode == MODE_DOUBLE && beeps_done >= DOUBLE_BEATS) begin
                  go_quiet();
               end else begin
                  held_level = '0;
                  tone_on    = 1'b0;
                  mark_ms    = now;
               end
            end else if (!tone_on && due) begin
               beeps_done = beeps_done + 3'd1;
               if (beeps_done > ((cur_mode == MODE_DOUBLE) ? DOUBLE_BEATS : TRIPLE_BEATS) ||
                   beeps_done == 3'd0) begin
                  go_quiet();
               end else begin
                  held_level = vol_set;
                  tone_on    = 1'b1;
                  mark_ms    = now;
               end
            end
         end
         MODE_CONT: held_level = vol_set;
         MODE_ALARM: begin
            if (due) begin
               alarm_high = ~alarm_high;
               held_level = alarm_high ? vol_set : '0;
               mark_ms    = now;
            end
         end
         default: held_level = '0;
      endcase
   endfunction

   function automatic void apply_mode(input logic [ModeBits-1:0] sel);
      if (sel > MODE_ALARM) return;
      if (!snd_en && sel != MODE_OFF) return;
      if (sel == MODE_OFF && tone_on && (cur_mode == MODE_ONCE || cur_mode == MODE_DOUBLE))
         return;
      mark_ms    = '0;
      beeps_done = 3'd0;
      tone_on    = 1'b0;
      alarm_high = 1'b0;
      cur_mode   = mode_type'(sel);
      held_level = (sel == MODE_CONT) ? vol_set : '0;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= ShowLimit) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic check_beat();
      drive_beat_type want;
      if (level_mode_q.size() == 0) begin
         flag_mismatch("result beat with nothing expected");
         return;
      end
      want = level_mode_q.pop_front();
      if (rsp_drive_level !== want.level)
         flag_mismatch($sformatf("drive_level %0d, expected %0d", rsp_drive_level, want.level));
      if (rsp_active_mode !== want.mode)
         flag_mismatch($sformatf("active_mode %0d, expected %0d", rsp_active_mode, want.mode));
      if (rsp_sounding !== want.sounding)
         flag_mismatch($sformatf("sounding %0b, expected %0b", rsp_sounding, want.sounding));
   endtask

   // offer one item, hold it until accepted, then predict its beat
   task automatic send_item(input logic op, input logic [ModeBits-1:0] sel,
                            input logic [NowBits-1:0] stamp, input logic typed,
                            input logic [VolumeBits-1:0] typed_level, input mode_type typed_mode);
      drive_beat_type beat;
      req_valid    <= 1'b1;
      req_op       <= op;
      req_new_mode <= sel;
      req_now_ms   <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_TICK) apply_tick(stamp);
      else apply_mode(sel);
      if (typed) beat = '{typed_level, typed_mode, typed_level != '0};
      else beat = '{held_level, cur_mode, held_level != '0};
      level_mode_q.push_back(beat);
   endtask

   task automatic idle_gap();
      if (!calm && $urandom_range(0, 99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (level_mode_q.size() != 0);
   endtask

   // register writes only while nothing is in flight; upper data bits are junk on purpose
   task automatic program_csr(input cfg_type cfg);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SOUND_ENABLE;
      csr_wdata <= {15'($urandom), cfg.sound_enable};
      @(posedge clock);
      snd_en = cfg.sound_enable;
      csr_index <= CSR_DRIVE_VOLUME;
      csr_wdata <= {8'($urandom), cfg.drive_volume};
      @(posedge clock);
      vol_set = cfg.drive_volume;
      csr_index <= CSR_UNMAPPED;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_index <= CSR_BEEP_MS;
      csr_wdata <= cfg.beep_ms;
      @(posedge clock);
      beep_len = cfg.beep_ms;
      csr_wr_en <= 1'b0;
   endtask

   // result side: random back-pressure plus two long hold-offs counted here
   initial begin : rsp_side
      int beats;
      int hold;
      beats = 0;
      hold  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            check_beat();
            beats++;
            if (beats == 733 || beats == 1621) hold = 300;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 12);
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      cfg_type            phase_cfg [PhaseCount];
      logic [NowBits-1:0] clock_ms;
      logic [NowBits-1:0] stride;
      logic [ModeBits-1:0] sel;
      int                 ticks_left;

      phase_cfg[0] = '{1'b1, 8'd255, 16'd1};
      phase_cfg[1] = '{1'b1, 8'd0, 16'd65535};
      phase_cfg[2] = '{1'b0, 8'd77, 16'd10};
      phase_cfg[3] = '{1'b1, 8'd1, 16'd0};
      phase_cfg[4] = '{1'b1, 8'($urandom), 16'($urandom_range(1, 40))};
      phase_cfg[5] = '{1'b1, 8'($urandom), 16'($urandom_range(1, 1000))};
      phase_cfg[6] = '{1'b1, 8'd200, 16'd3};
      phase_cfg[7] = '{1'b1, 8'($urandom), 16'($urandom_range(1, 65535))};
      clock_ms   = $urandom;
      ticks_left = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < PlanRows; r++) begin
         send_item(PLAN[r].op, PLAN[r].sel, PLAN[r].stamp, PLAN[r].typed,
                   PLAN[r].level, PLAN[r].mode);
         idle_gap();
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         drain_results();
         program_csr(phase_cfg[ph]);
         calm = (ph == 4);
         for (int n = 0; n < PhaseItems; n++) begin
            if (ph == 5 && n == PhaseItems / 2) drain_results();
            if ($urandom_range(0, 99) < 8) begin
               // noise: any op, any mode code, any timestamp
               send_item(1'($urandom), 3'($urandom), $urandom, 1'b0, '0, MODE_OFF);
            end else if (ticks_left != 0 && $urandom_range(0, 19) == 0) begin
               send_item(OP_MODE, MODE_OFF, $urandom, 1'b0, '0, MODE_OFF);
            end else if (ticks_left == 0) begin
               sel = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
               send_item(OP_MODE, sel, $urandom, 1'b0, '0, MODE_OFF);
               ticks_left = $urandom_range(2, 12);
            end else begin
               stride = ($urandom_range(0, 15) == 0) ? $urandom
                        : $urandom_range(0, 2 * int'(beep_len) + 2);
               clock_ms = clock_ms + stride;
               send_item(OP_TICK, 3'($urandom), clock_ms, 1'b0, '0, MODE_OFF);
               ticks_left--;
            end
            idle_gap();
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
sv/bbps_pkg.sv
sv/bbps_csr.sv
sv/bbps_in_stage.sv
sv/bbps_core.sv
sv/buzzer_beep_pattern_sequencer.sv
sv/bbps_checker.sv
tb/tb_buzzer_beep_pattern_sequencer.sv
